FILE: hw/rtl/nnt3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nnt3_pkg
// Shared constants and types of the nearest-neighbour top-three matcher.
// ---------------------------------------------------------------------------
package nnt3_pkg;

	localparam int MAX_FEATURES = 512;
	localparam int TOP_K        = 3;
	localparam int EMIT_LIMIT   = 3;

	localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int IDX_W  = 9;
	localparam int VAL_W  = 16;
	localparam int ID_W   = 16;
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int DIST_W = 41;
	localparam int ROOT_W = 21;
	localparam int RANK_W = 2;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_REF    = 2'd1,
		OP_FINISH = 2'd2
	} nnt3_op_t;

	// one slot of the sorted list
	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] sqd;
		logic [ID_W-1:0]   id;
	} nnt3_entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic clr;
	} nnt3_cell_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nnt3_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nnt3_cell
// One slot of the sorted top-k list. Inserts shift entries down the chain,
// pops shift them up towards slot zero.
// ---------------------------------------------------------------------------
module nnt3_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire nnt3_pkg::nnt3_cell_ctl_t ctl,
	input  wire nnt3_pkg::nnt3_entry_t    new_ent,
	input  wire nnt3_pkg::nnt3_entry_t    up_ent,
	input  wire                           up_take,
	input  wire nnt3_pkg::nnt3_entry_t    lo_ent,
	output nnt3_pkg::nnt3_entry_t         ent,
	output logic                          take
);

	nnt3_pkg::nnt3_entry_t ent_q;

	// new entry goes at or above this slot; ties keep the lower id first
	always_comb begin
		take = !ent_q.vld || (new_ent.sqd < ent_q.sqd) ||
			((new_ent.sqd == ent_q.sqd) && (new_ent.id < ent_q.id));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.clr) begin
			ent_q.vld <= 1'b0;
		end else if (ctl.pop) begin
			ent_q <= lo_ent;
		end else if (ctl.ins && take) begin
			ent_q <= up_take ? up_ent : new_ent;
		end
	end

	assign ent = ent_q;

endmodule
`default_nettype wire

FILE: hw/rtl/nnt3_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nnt3_isqrt
// Floored integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module nnt3_isqrt (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire  [nnt3_pkg::DIST_W-1:0]        operand,
	output logic                               done,
	output logic [nnt3_pkg::ROOT_W-1:0]        root
);

	localparam int RW   = nnt3_pkg::ROOT_W;
	localparam int OPW  = 2 * RW;
	localparam int CNTW = $clog2(RW + 1);

	logic [OPW-1:0]  op_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [RW+2:0]   rem_sh;
	logic [RW+2:0]   trial;
	logic            ge;
	logic [RW+2:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, op_q[OPW-1:OPW-2]};
		trial   = (RW + 3)'({root_q, 2'b01});
		ge      = rem_sh >= trial;
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= OPW'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[OPW-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hw/rtl/nearest_neighbor_top3_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nearest_neighbor_top3_matcher
// Top-three nearest-neighbour search by squared Euclidean distance.
// ---------------------------------------------------------------------------
// Query and reference requests are taken one per cycle while no finish is
// in progress: a reference element reads the query memory, then runs
// through subtract, square and a saturating accumulate, and at vector end
// the sum enters a chain of list cells that keep the three nearest in order
// (ties to the lower id). A finish request waits for the pipeline to drain,
// then emits each held entry after a bit-serial square root and a capture
// into the output registers; the input stays stalled until the last result
// is taken. An empty list gives one result with found low. The sum clears
// once the pipeline has drained; the list clears when the last result is
// taken.
module nearest_neighbor_top3_matcher (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [1:0]         opcode,
	input  wire  [8:0]         feature_index,
	input  wire signed [15:0]  feature_value,
	input  wire  [15:0]        entry_id,
	input  wire                vector_end,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [1:0]         rank,
	output logic [15:0]        match_id,
	output logic [40:0]        squared_distance,
	output logic [20:0]        distance,
	output logic               found,
	output logic               last
);

	localparam int TOP_K  = nnt3_pkg::TOP_K;
	localparam int ADDR_W = nnt3_pkg::ADDR_W;
	localparam int VAL_W  = nnt3_pkg::VAL_W;
	localparam int ID_W   = nnt3_pkg::ID_W;
	localparam int MAG_W  = nnt3_pkg::MAG_W;
	localparam int SQ_W   = nnt3_pkg::SQ_W;
	localparam int DIST_W = nnt3_pkg::DIST_W;
	localparam int ROOT_W = nnt3_pkg::ROOT_W;
	localparam int RANK_W = nnt3_pkg::RANK_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_ROOT  = 4'b0100,
		ST_OUT   = 4'b1000
	} nnt3_state_t;

	nnt3_state_t state_q;

	logic in_acc;
	logic out_acc;
	logic q_we;
	logic ref_go;
	logic fin_go;
	logic idx_ok;
	logic [ADDR_W-1:0] addr;

	logic signed [VAL_W-1:0] query_mem [nnt3_pkg::MAX_FEATURES];

	// pipeline
	logic                    v_s1, v_s2, v_s3;
	logic signed [VAL_W-1:0] q_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic                    ok_s1;
	logic                    end_s1, end_s2, end_s3;
	logic [ID_W-1:0]         id_s1, id_s2, id_s3;
	logic [MAG_W-1:0]        mag_s2;
	logic [SQ_W-1:0]         sq_s3;
	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          diff_abs;
	logic [DIST_W:0]         sum_wide;
	logic [DIST_W-1:0]       sum_sat;
	logic [DIST_W-1:0]       sum_q;
	logic                    ins_v_q;
	logic [DIST_W-1:0]       ins_d_q;
	logic [ID_W-1:0]         ins_id_q;
	logic                    pipe_busy;

	// list chain
	nnt3_pkg::nnt3_cell_ctl_t ctl;
	nnt3_pkg::nnt3_entry_t    new_ent;
	nnt3_pkg::nnt3_entry_t    ent    [TOP_K];
	nnt3_pkg::nnt3_entry_t    up_ent [TOP_K];
	nnt3_pkg::nnt3_entry_t    lo_ent [TOP_K];
	logic                     take   [TOP_K];
	logic                     up_take[TOP_K];

	// emission
	logic                sq_start;
	logic                sq_done;
	logic [ROOT_W-1:0]   sq_root;
	logic [RANK_W-1:0]   rank_q;
	logic [RANK_W-1:0]   o_rank_q;
	logic [ID_W-1:0]     o_id_q;
	logic [DIST_W-1:0]   o_sq_q;
	logic [ROOT_W-1:0]   o_dist_q;
	logic                o_found_q;
	logic                o_last_q;
	logic                is_last;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	assign idx_ok = 32'(feature_index) < nnt3_pkg::MAX_FEATURES;
	assign addr   = ADDR_W'(feature_index);

	always_comb begin
		q_we   = 1'b0;
		ref_go = 1'b0;
		fin_go = 1'b0;
		unique case (opcode)
			nnt3_pkg::OP_QUERY:  q_we   = in_acc && idx_ok;
			nnt3_pkg::OP_REF:    ref_go = in_acc;
			nnt3_pkg::OP_FINISH: fin_go = in_acc;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			query_mem[addr] <= feature_value;
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= query_mem[addr];
	end

	// stage payloads
	always_comb begin
		diff     = (VAL_W + 1)'(val_s1) - (ok_s1 ? (VAL_W + 1)'(q_s1) : '0);
		diff_abs = diff[VAL_W] ? (VAL_W + 1)'(-diff) : (VAL_W + 1)'(diff);
		sum_wide = (DIST_W + 1)'(sum_q) + (DIST_W + 1)'(sq_s3);
		sum_sat  = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		val_s1 <= feature_value;
		ok_s1  <= idx_ok;
		end_s1 <= vector_end;
		id_s1  <= entry_id;
		mag_s2 <= diff_abs[MAG_W-1:0];
		end_s2 <= end_s1;
		id_s2  <= id_s1;
		sq_s3  <= mag_s2 * mag_s2;
		end_s3 <= end_s2;
		id_s3  <= id_s2;
		ins_d_q  <= sum_sat;
		ins_id_q <= id_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ins_v_q <= 1'b0;
			sum_q   <= '0;
		end else begin
			v_s1    <= ref_go;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			ins_v_q <= v_s3 && end_s3;
			if (v_s3) begin
				sum_q <= end_s3 ? '0 : sum_sat;
			end else if (state_q == ST_DRAIN && !pipe_busy) begin
				sum_q <= '0;
			end
		end
	end

	assign pipe_busy = v_s1 || v_s2 || v_s3 || ins_v_q;

	// list cells
	always_comb begin
		new_ent.vld = 1'b1;
		new_ent.sqd = ins_d_q;
		new_ent.id  = ins_id_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < TOP_K; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign up_ent[gi]  = '0;
				assign up_take[gi] = 1'b0;
			end else begin : g_body
				assign up_ent[gi]  = ent[gi-1];
				assign up_take[gi] = take[gi-1];
			end
			if (gi == TOP_K - 1) begin : g_tail
				assign lo_ent[gi] = '0;
			end else begin : g_mid
				assign lo_ent[gi] = ent[gi+1];
			end

			nnt3_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.new_ent (new_ent),
				.up_ent  (up_ent[gi]),
				.up_take (up_take[gi]),
				.lo_ent  (lo_ent[gi]),
				.ent     (ent[gi]),
				.take    (take[gi])
			);
		end
	endgenerate

	// emission control
	assign is_last = (rank_q == RANK_W'(nnt3_pkg::EMIT_LIMIT - 1)) || !lo_ent[0].vld;

	always_comb begin
		sq_start = 1'b0;
		if (state_q == ST_DRAIN && !pipe_busy && ent[0].vld) begin
			sq_start = 1'b1;
		end else if (state_q == ST_OUT && out_acc && !o_last_q) begin
			sq_start = 1'b1;
		end
	end

	always_comb begin
		ctl.ins = ins_v_q;
		ctl.pop = (state_q == ST_ROOT) && sq_done;
		ctl.clr = out_acc && o_last_q;
	end

	nnt3_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (ent[0].sqd),
		.done    (sq_done),
		.root    (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rank_q   <= '0;
			o_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fin_go) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						rank_q <= '0;
						if (ent[0].vld) begin
							state_q <= ST_ROOT;
						end else begin
							o_last_q <= 1'b1;
							state_q  <= ST_OUT;
						end
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						o_last_q <= is_last;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (o_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							rank_q  <= rank_q + 1'b1;
							state_q <= ST_ROOT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && !pipe_busy && !ent[0].vld) begin
			o_rank_q  <= '0;
			o_id_q    <= '0;
			o_sq_q    <= '0;
			o_dist_q  <= '0;
			o_found_q <= 1'b0;
		end else if (state_q == ST_ROOT && sq_done) begin
			o_rank_q  <= rank_q;
			o_id_q    <= ent[0].id;
			o_sq_q    <= ent[0].sqd;
			o_dist_q  <= sq_root;
			o_found_q <= 1'b1;
		end
	end

	assign rank             = o_rank_q;
	assign match_id         = o_id_q;
	assign squared_distance = o_sq_q;
	assign distance         = o_dist_q;
	assign found            = o_found_q;
	assign last             = o_last_q;

`ifndef SYNTHESIS
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |->
			(42'(distance) * 42'(distance) <= 42'(squared_distance)) &&
			(42'(distance + 21'd1) * 42'(distance + 21'd1) > 42'(squared_distance)))
		else $error("distance is not the floored root of squared_distance");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last && (rank == '0))
		else $error("empty ranking result not marked last");

	a_no_ins_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ins_v_q |-> (state_q == ST_IDLE) || (state_q == ST_DRAIN))
		else $error("list insertion during emission");

	generate
		for (gi = 1; gi < TOP_K; gi++) begin : g_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				ent[gi].vld |-> ent[gi-1].vld && (ent[gi-1].sqd <= ent[gi].sqd))
				else $error("list cells out of order or not contiguous");
		end
	endgenerate
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbour top-three matcher. A scoreboard
// class keeps its own query memory, running sum and sorted three-entry list,
// works out the ranking that each finish request should emit and checks the
// results in order. The stimulus covers directed corner cases and random
// vector groups, with random gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0]  OP_SPARE    = 2'd3;
	localparam logic [41:0] SUM_CEILING = (42'd1 << 41) - 42'd1;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          RANDOM_REQS = 280;

	typedef struct {
		logic [1:0]  rank;
		logic [15:0] match_id;
		logic [40:0] sq_dist;
		logic [20:0] root;
		logic        found;
		logic        last;
	} ranked_match_t;

	class ranking_board;
		logic signed [15:0] query_mem [nnt3_pkg::MAX_FEATURES];
		logic [41:0]        acc;
		logic [41:0]        near_dist [nnt3_pkg::TOP_K];
		logic [15:0]        near_id [nnt3_pkg::TOP_K];
		int                 near_count;
		ranked_match_t      awaited_matches [$];
		int                 errors;
		int                 checked;

		function new();
			foreach (query_mem[i]) query_mem[i] = '0;
			errors = 0;
			checked = 0;
			clear_ranking();
		endfunction

		function void clear_ranking();
			acc = '0;
			near_count = 0;
			foreach (near_dist[i]) begin
				near_dist[i] = '0;
				near_id[i] = '0;
			end
		endfunction

		function logic [20:0] floor_root(logic [40:0] n);
			logic [20:0] r;
			logic [63:0] t;
			r = '0;
			for (int b = 20; b >= 0; b--) begin
				t = {43'd0, r | (21'd1 << b)};
				if (t * t <= {23'd0, n})
					r = t[20:0];
			end
			return r;
		endfunction

		// equal distances: a newcomer goes after entries with a lower or equal id
		function void place_entry(logic [41:0] d, logic [15:0] id);
			int slot;
			slot = 0;
			for (int i = 0; i < near_count; i++)
				if (near_dist[i] < d || (near_dist[i] == d && near_id[i] <= id))
					slot = i + 1;
			if (slot >= nnt3_pkg::TOP_K)
				return;
			for (int i = nnt3_pkg::TOP_K - 1; i > slot; i--) begin
				near_dist[i] = near_dist[i-1];
				near_id[i] = near_id[i-1];
			end
			near_dist[slot] = d;
			near_id[slot] = id;
			if (near_count < nnt3_pkg::TOP_K)
				near_count++;
		endfunction

		function void note_request(logic [1:0] op, logic [8:0] idx, logic signed [15:0] val,
				logic [15:0] id, logic vend);
			logic signed [17:0] diff;
			logic [63:0]        total;
			ranked_match_t      m;
			case (op)
				nnt3_pkg::OP_QUERY: query_mem[idx] = val;
				nnt3_pkg::OP_REF: begin
					diff = val - query_mem[idx];
					if (diff < 0)
						diff = -diff;
					total = {22'd0, acc} + 64'(diff) * 64'(diff);
					if (total > {22'd0, SUM_CEILING})
						total = {22'd0, SUM_CEILING};
					acc = total[41:0];
					if (vend) begin
						place_entry(acc, id);
						acc = '0;
					end
				end
				nnt3_pkg::OP_FINISH: begin
					if (near_count == 0) begin
						m = '{rank: '0, match_id: '0, sq_dist: '0, root: '0, found: 1'b0,
							last: 1'b1};
						awaited_matches = {awaited_matches, m};
					end
					for (int k = 0; k < near_count && k < nnt3_pkg::EMIT_LIMIT; k++) begin
						m.rank = 2'(k);
						m.match_id = near_id[k];
						m.sq_dist = near_dist[k][40:0];
						m.root = floor_root(near_dist[k][40:0]);
						m.found = 1'b1;
						m.last = (k == near_count - 1) || (k == nnt3_pkg::EMIT_LIMIT - 1);
						awaited_matches = {awaited_matches, m};
					end
					clear_ranking();
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(logic [1:0] r, logic [15:0] id, logic [40:0] sq,
				logic [20:0] root, logic fnd, logic lst);
			ranked_match_t m;
			if (awaited_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual rank %0d id %0d dist %0d",
					$time, r, id, sq);
				return;
			end
			m = awaited_matches.pop_front();
			checked++;
			compare_field("rank", m.rank, r);
			compare_field("match_id", m.match_id, id);
			compare_field("squared_distance", m.sq_dist, sq);
			compare_field("distance", m.root, root);
			compare_field("found", m.found, fnd);
			compare_field("last", m.last, lst);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [8:0]  feature_index;
	logic [15:0] feature_value;
	logic [15:0] entry_id;
	logic        vector_end;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  rank;
	logic [15:0] match_id;
	logic [40:0] squared_distance;
	logic [20:0] distance;
	logic        found;
	logic        last;

	ranking_board board;
	int          cycle_count = 0;
	int          work_sent = 0;
	int          finish_sent = 0;
	bit          calm = 1'b0;
	bit          is_loaded [nnt3_pkg::MAX_FEATURES];
	int          loaded_idx [$];
	int          vec_idx [$];
	logic [15:0] vec_val [$];

	nearest_neighbor_top3_matcher u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.feature_index    (feature_index),
		.feature_value    (feature_value),
		.entry_id         (entry_id),
		.vector_end       (vector_end),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rank             (rank),
		.match_id         (match_id),
		.squared_distance (squared_distance),
		.distance         (distance),
		.found            (found),
		.last             (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one; none during calm stretches
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// sampled mid-cycle: stall is settled and holds until the next edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(rank, match_id, squared_distance, distance, found, last);
	end

	task automatic push_request(logic [1:0] op, int idx, logic [15:0] val, logic [15:0] id,
			logic vend);
		int  pause;
		bit  taken;
		pause = idle_len();
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		feature_index <= 9'(idx);
		feature_value <= val;
		entry_id <= id;
		vector_end <= vend;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				board.note_request(op, 9'(idx), val, id, vend);
			@(posedge clk);
		end while (!taken);
		if (op != OP_SPARE)
			work_sent++;
		if (op == nnt3_pkg::OP_FINISH)
			finish_sent++;
	endtask

	task automatic load_query(int idx, logic [15:0] val);
		push_request(nnt3_pkg::OP_QUERY, idx, val, 16'($urandom), 1'($urandom));
		if (!is_loaded[idx]) begin
			is_loaded[idx] = 1'b1;
			loaded_idx = {loaded_idx, idx};
		end
	endtask

	task automatic finish_ranking();
		push_request(nnt3_pkg::OP_FINISH, $urandom_range(0, 511), 16'($urandom),
			16'($urandom), 1'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.awaited_matches.size() > 0)
			@(posedge clk);
	endtask

	// entry_id on inner elements is junk; the block only takes it at vector end
	task automatic send_vector(logic [15:0] id);
		for (int i = 0; i < vec_idx.size(); i++)
			push_request(nnt3_pkg::OP_REF, vec_idx[i], vec_val[i],
				(i == vec_idx.size() - 1) ? id : 16'($urandom), i == vec_idx.size() - 1);
	endtask

	function automatic logic [15:0] pick_value(int idx);
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return board.query_mem[idx] + 16'($urandom_range(0, 3));
		if (r < 45)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_id();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	initial begin
		int start_sent;
		int roll;
		int nvec;
		int idx;
		logic [15:0] pv;
		board = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= nnt3_pkg::OP_QUERY;
		feature_index <= '0;
		feature_value <= '0;
		entry_id <= '0;
		vector_end <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list gives a single not-found result
		finish_ranking();
		load_query(0, 16'h7FFF);
		load_query(511, 16'h8000);
		load_query(1, 16'h0000);
		load_query(2, 16'h5555);
		load_query(256, 16'hAAAA);
		// largest differences both ways
		push_request(nnt3_pkg::OP_REF, 0, 16'h8000, 16'h1234, 1'b0);
		push_request(nnt3_pkg::OP_REF, 511, 16'h7FFF, 16'hFFFF, 1'b1);
		// three zero distances: ties settle on id, the far vector drops out
		push_request(nnt3_pkg::OP_REF, 1, 16'h0000, 16'h0000, 1'b1);
		push_request(nnt3_pkg::OP_REF, 1, 16'h0000, 16'h0005, 1'b1);
		push_request(nnt3_pkg::OP_REF, 2, 16'h5555, 16'h0003, 1'b1);
		push_request(OP_SPARE, 511, 16'hFFFF, 16'hFFFF, 1'b1);
		push_request(nnt3_pkg::OP_REF, 256, 16'h5555, 16'hBEEF, 1'b0);
		push_request(nnt3_pkg::OP_REF, 2, 16'h0000, 16'h00FF, 1'b1);
		finish_ranking();
		push_request(nnt3_pkg::OP_REF, 1, 16'h0100, 16'h0042, 1'b1);
		finish_ranking();
		push_request(nnt3_pkg::OP_REF, 0, 16'h7FFF, 16'h0007, 1'b1);
		push_request(nnt3_pkg::OP_REF, 511, 16'h7FFF, 16'h0002, 1'b1);
		finish_ranking();
		// query survives a finish and can be rewritten
		load_query(0, 16'h0000);
		push_request(nnt3_pkg::OP_REF, 0, 16'h0003, 16'h0011, 1'b1);
		finish_ranking();
		drain_results();

		start_sent = work_sent;
		while (work_sent - start_sent < RANDOM_REQS) begin
			roll = $urandom_range(0, 99);
			calm = ($urandom_range(0, 9) == 0);
			if (roll < 8) begin
				idx = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 511 : 0)
					: $urandom_range(0, 511);
				load_query(idx, $urandom_range(0, 3) ? 16'($urandom) : 16'h8000);
			end else if (roll < 12) begin
				push_request(OP_SPARE, $urandom_range(0, 511), 16'($urandom), 16'($urandom),
					1'($urandom));
			end else if (roll < 17) begin
				// broken run: a vector cut short by finish, or a finish on its own
				if ($urandom_range(0, 1)) begin
					idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
					push_request(nnt3_pkg::OP_REF, idx, pick_value(idx), 16'($urandom), 1'b0);
				end
				finish_ranking();
			end else begin
				nvec = $urandom_range(1, 6);
				for (int v = 0; v < nvec; v++) begin
					// repeat the last vector under another id now and then to force ties
					if (vec_idx.size() == 0 || $urandom_range(0, 3) != 0) begin
						vec_idx.delete();
						vec_val.delete();
						repeat ($urandom_range(1, 5)) begin
							idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
							pv = pick_value(idx);
							vec_idx = {vec_idx, idx};
							vec_val = {vec_val, pv};
						end
					end
					send_vector(pick_id());
				end
				finish_ranking();
				if ($urandom_range(0, 9) == 0)
					drain_results();
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (board.awaited_matches.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests including %0d finish requests, with ties and empty lists",
			work_sent, finish_sent);
		$display("Checked %0d ranked results, %0d mismatches", board.checked, board.errors);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/nnt3_pkg.sv
hw/rtl/nnt3_cell.sv
hw/rtl/nnt3_isqrt.sv
hw/rtl/nearest_neighbor_top3_matcher.sv
bench/tb_top.sv
